// ===== src/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WGM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/wgm_pkg.sv =====
package wgm_pkg;

  localparam int PATTERN_CHARS = 32;
  localparam int NPOS          = PATTERN_CHARS + 1;
  localparam int LEVELS        = $clog2(NPOS);
  localparam int CHAR_W        = 8;
  localparam int WORD_W        = 64;
  localparam int CHARS_PER_WORD = WORD_W / CHAR_W;
  localparam int WORDS         = 4;
  localparam int LEN_W         = 6;
  localparam int IDX_W         = 3;

  localparam logic [CHAR_W-1:0] STAR_CHAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR    = 8'h3F;
  localparam logic [CHAR_W-1:0] END_CHAR    = 8'h00;
  localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [IDX_W-1:0] {
    REG_WORD_0   = 3'd0,
    REG_WORD_1   = 3'd1,
    REG_WORD_2   = 3'd2,
    REG_WORD_3   = 3'd3,
    REG_LENGTH   = 3'd4,
    REG_FOLD     = 3'd5,
    REG_CONTAINS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic step;
    logic restart;
    logic wrap;
  } cell_ctl_t;

endpackage

// ===== src/wgm_closure.sv =====
module wgm_closure
  import wgm_pkg::*;
(
  input  logic [NPOS-1:0]          act_i,
  input  logic [PATTERN_CHARS-1:0] star_i,
  output logic [NPOS-1:0]          closed_o
);

  // A star position hands its activity on to the next position. The chain of
  // stars is resolved as a parallel prefix over LEVELS stages.
  logic [NPOS-1:0] gen_lv  [0:LEVELS];
  logic [NPOS-1:0] prop_lv [0:LEVELS];

  always_comb begin
    gen_lv[0]  = act_i;
    prop_lv[0] = {star_i, 1'b0};
    for (int lv = 0; lv < LEVELS; lv++) begin
      for (int j = 0; j < NPOS; j++) begin
        if (j >= (1 << lv)) begin
          gen_lv[lv+1][j]  = gen_lv[lv][j] | (prop_lv[lv][j] & gen_lv[lv][j-(1<<lv)]);
          prop_lv[lv+1][j] = prop_lv[lv][j] & prop_lv[lv][j-(1<<lv)];
        end else begin
          gen_lv[lv+1][j]  = gen_lv[lv][j];
          prop_lv[lv+1][j] = prop_lv[lv][j];
        end
      end
    end
    closed_o = gen_lv[LEVELS];
  end

endmodule

// ===== src/wgm_cell.sv =====
module wgm_cell
  import wgm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              first,
  input  logic              cur,
  input  logic              in_use,
  input  logic              is_end,
  input  logic [CHAR_W-1:0] pchar,
  input  logic [CHAR_W-1:0] ch,
  input  logic              adv_in,
  output logic              adv_out,
  output logic              act
);

  logic act_r;
  logic act_nxt;
  logic is_star;
  logic stay;

  assign is_star = (pchar == STAR_CHAR);
  assign stay    = cur & in_use & is_star;
  assign adv_out = cur & in_use & ~is_star & ((pchar == ANY_CHAR) | (pchar == ch));
  assign act     = act_r;

  always_comb begin
    act_nxt = act_r;
    if (ctl.restart) begin
      act_nxt = first;
    end else if (ctl.step) begin
      act_nxt = stay | adv_in | (ctl.wrap & (first | (is_end & cur)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= first;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

// ===== src/wildcard_glob_match.sv =====
// Channel | Direction | Ports                           | Transfer when
// in      | input     | in_valid, in_ready, in_character | in_valid & in_ready
// out     | output    | out_valid, out_ready, out_matched | out_valid & out_ready
// cfg     | input     | cfg_we, cfg_index, cfg_data       | cfg_we
//
// One character is taken in every cycle while in_ready is high; each one updates the
// row of position cells, and the star closure is a six-level prefix network.
// A zero character yields its result in the cycle after its transfer.
// Reset is synchronous and leaves only the first position active.
// A zero character is held off only while an earlier result waits on out_ready.
`include "assert_macros.svh"

module wildcard_glob_match
  import wgm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_character,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  logic [WORD_W-1:0] pat_word_r [0:WORDS-1];
  logic [LEN_W-1:0]  pat_len_r;
  logic              fold_r;
  logic              contains_r;
  logic              out_valid_r;
  logic              out_matched_r;

  logic [CHAR_W-1:0]        pchar [0:NPOS-1];
  logic [NPOS-1:0]          in_use;
  logic [NPOS-1:0]          is_end;
  logic [PATTERN_CHARS-1:0] star_pos;
  logic                     any_wild;
  logic                     wrap;
  logic [CHAR_W-1:0]        ch;
  logic [NPOS-1:0]          act;
  logic [NPOS-1:0]          cur_open;
  logic [NPOS-1:0]          cur;
  logic [NPOS:0]            adv;
  logic                     matched;
  logic                     in_fire;
  logic                     is_term;
  cell_ctl_t                ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
      pat_len_r  <= '0;
      fold_r     <= 1'b1;
      contains_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WORD_0:   pat_word_r[0] <= cfg_data;
        REG_WORD_1:   pat_word_r[1] <= cfg_data;
        REG_WORD_2:   pat_word_r[2] <= cfg_data;
        REG_WORD_3:   pat_word_r[3] <= cfg_data;
        REG_LENGTH:   pat_len_r     <= cfg_data[LEN_W-1:0];
        REG_FOLD:     fold_r        <= cfg_data[0];
        REG_CONTAINS: contains_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pattern ends at its length or at the first zero byte, whichever is first.
  always_comb begin
    logic run;
    run      = 1'b1;
    any_wild = 1'b0;
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      pchar[i]    = pat_word_r[i / CHARS_PER_WORD][(i % CHARS_PER_WORD)*CHAR_W +: CHAR_W];
      run         = run & (pchar[i] != END_CHAR) & (LEN_W'(i) < pat_len_r);
      in_use[i]   = run;
      star_pos[i] = run & (pchar[i] == STAR_CHAR);
      any_wild    = any_wild | star_pos[i] | (run & (pchar[i] == ANY_CHAR));
    end
    pchar[NPOS-1]  = END_CHAR;
    in_use[NPOS-1] = 1'b0;
    is_end[0]      = ~in_use[0];
    for (int j = 1; j < NPOS; j++) begin
      is_end[j] = in_use[j-1] & ~in_use[j];
    end
  end

  assign wrap = contains_r & in_use[0] & ~any_wild;
  assign ch   = (fold_r && in_character >= LOWER_A && in_character <= LOWER_Z) ?
                (in_character - CASE_OFFSET) : in_character;

  assign cur_open = act | {{(NPOS-1){1'b0}}, wrap};

  wgm_closure u_closure (
    .act_i    (cur_open),
    .star_i   (star_pos),
    .closed_o (cur)
  );

  assign matched  = |(cur & is_end);
  assign is_term  = (in_character == END_CHAR);
  assign in_ready = ~out_valid_r | out_ready | ~is_term;
  assign in_fire  = in_valid & in_ready;

  assign ctl.step    = in_fire & ~is_term;
  assign ctl.restart = in_fire & is_term;
  assign ctl.wrap    = wrap;

  assign adv[0] = 1'b0;

  for (genvar g = 0; g < NPOS; g++) begin : g_cell
    wgm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .first   (g == 0),
      .cur     (cur[g]),
      .in_use  (in_use[g]),
      .is_end  (is_end[g]),
      .pchar   (pchar[g]),
      .ch      (ch),
      .adv_in  (adv[g]),
      .adv_out (adv[g+1]),
      .act     (act[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.restart) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.restart) begin
      out_matched_r <= matched;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  `WGM_ASSERT_NXT(a_restart_vec, clk, rst_n, ctl.restart, act == NPOS'(1))
  `WGM_ASSERT_NXT(a_result_out, clk, rst_n, ctl.restart, out_valid_r)
  `WGM_ASSERT_NXT(a_wrap_keeps_start, clk, rst_n, ctl.step && wrap, act[0])
  `WGM_ASSERT_IMP(a_no_adv_past_end, clk, rst_n, 1'b1, !adv[NPOS])

endmodule
